/* rtl/core/utf8_string_validator_assert.svh */
// ---------------------------------------------------------------------------
// UTF-8 string validator assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_STRING_VALIDATOR_ASSERT_SVH
`define UTF8_STRING_VALIDATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8V_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/u8v_pkg.sv */
// ---------------------------------------------------------------------------
// UTF-8 string validator package
// Widths, byte class limits and the types shared by the validator modules.
// ---------------------------------------------------------------------------
package u8v_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = BYTE_W + 1;
	localparam int PEND_W  = 2;
	localparam int CP_W    = 21;

	localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd128;

	localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF4;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;
	localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
	localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;

	localparam logic [PEND_W-1:0] SEQ_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] SEQ_TWO   = 2'd1;
	localparam logic [PEND_W-1:0] SEQ_THREE = 2'd2;
	localparam logic [PEND_W-1:0] SEQ_FOUR  = 2'd3;

	// One input beat as held in the input register.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              is_last;
	} beat_t;

	// Input stage handing a beat to the decoder.
	typedef struct packed {
		logic  step;
		beat_t beat;
	} stage_t;

endpackage

/* rtl/core/u8v_in_reg.sv */
// ---------------------------------------------------------------------------
// UTF-8 validator input register
// Holds one accepted beat and releases it; a closing beat waits until the result side has room.
// ---------------------------------------------------------------------------
module u8v_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [u8v_pkg::BYTE_W-1:0] s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  logic                       s_axis_tlast,
	input  logic                       out_free,
	output u8v_pkg::stage_t            stage
);
	import u8v_pkg::*;

	logic  valid_s1;
	beat_t beat_s1;
	logic  advance;

	// Only a closing beat needs a free result slot.
	assign advance       = valid_s1 && (!beat_s1.is_last || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beat_s1.data_byte <= s_axis_tdata;
			beat_s1.has_byte  <= s_axis_tuser;
			beat_s1.is_last   <= s_axis_tlast;
		end
	end

	assign stage.step = advance;
	assign stage.beat = beat_s1;

endmodule

/* rtl/core/u8v_decode.sv */
// ---------------------------------------------------------------------------
// UTF-8 validator decoder
// Per-string decode state and the combinational update for one byte.
// ---------------------------------------------------------------------------
module u8v_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  u8v_pkg::stage_t            stage,
	input  logic [u8v_pkg::BYTE_W-1:0] max_length,
	output logic                       verdict
);
	import u8v_pkg::*;

	logic [COUNT_W-1:0] count_q, count_d;
	logic [PEND_W-1:0]  pend_q, pend_d;
	logic [PEND_W-1:0]  seq_q, seq_d;
	logic [CP_W-1:0]    cp_q, cp_d;
	logic               failed_q, failed_d;

	logic [COUNT_W-1:0] max_ext;
	logic [BYTE_W-1:0]  b;
	logic [CP_W-1:0]    cp_cont;
	logic               cp_bad;

	assign max_ext = {1'b0, max_length};
	assign b       = stage.beat.data_byte;
	assign cp_cont = {cp_q[CP_W-7:0], b[5:0]};

	// Range check of a code point completed by this continuation byte.
	always_comb begin
		cp_bad = (cp_cont > CP_MAX) || ((cp_cont >= SURR_LO) && (cp_cont <= SURR_HI));
		case (seq_q)
			SEQ_TWO:   cp_bad = cp_bad || (cp_cont < MIN_TWO);
			SEQ_THREE: cp_bad = cp_bad || (cp_cont < MIN_THREE);
			SEQ_FOUR:  cp_bad = cp_bad || (cp_cont < MIN_FOUR);
			default:   cp_bad = cp_bad;
		endcase
	end

	always_comb begin
		count_d  = count_q;
		pend_d   = pend_q;
		seq_d    = seq_q;
		cp_d     = cp_q;
		failed_d = failed_q;
		if (stage.beat.has_byte) begin
			if (count_q <= max_ext) begin
				count_d = count_q + 1'b1;
			end
			if (count_d > max_ext) begin
				failed_d = 1'b1;
			end
			if (pend_q == SEQ_NONE) begin
				if (b == NUL_BYTE) begin
					failed_d = 1'b1;
				end else if (b < ASCII_LIM) begin
					failed_d = failed_d;
				end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
					pend_d = SEQ_TWO;
					seq_d  = SEQ_TWO;
					cp_d   = {{(CP_W-5){1'b0}}, b[4:0]};
				end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
					pend_d = SEQ_THREE;
					seq_d  = SEQ_THREE;
					cp_d   = {{(CP_W-4){1'b0}}, b[3:0]};
				end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
					pend_d = SEQ_FOUR;
					seq_d  = SEQ_FOUR;
					cp_d   = {{(CP_W-3){1'b0}}, b[2:0]};
				end else begin
					failed_d = 1'b1;
				end
			end else begin
				if ((b & CONT_MASK) != CONT_MARK) begin
					failed_d = 1'b1;
				end
				cp_d   = cp_cont;
				pend_d = pend_q - 1'b1;
				if ((pend_d == SEQ_NONE) && cp_bad) begin
					failed_d = 1'b1;
				end
			end
		end
	end

	assign verdict = !failed_d && (pend_d == SEQ_NONE) && (count_d <= max_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pend_q   <= SEQ_NONE;
			seq_q    <= SEQ_NONE;
			cp_q     <= '0;
			failed_q <= 1'b0;
		end else if (stage.step) begin
			if (stage.beat.is_last) begin
				count_q  <= '0;
				pend_q   <= SEQ_NONE;
				seq_q    <= SEQ_NONE;
				cp_q     <= '0;
				failed_q <= 1'b0;
			end else begin
				count_q  <= count_d;
				pend_q   <= pend_d;
				seq_q    <= seq_d;
				cp_q     <= cp_d;
				failed_q <= failed_d;
			end
		end
	end

endmodule

/* rtl/core/u8v_out_reg.sv */
// ---------------------------------------------------------------------------
// UTF-8 validator result register
// Holds one verdict until the downstream side takes it.
// ---------------------------------------------------------------------------
module u8v_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       verdict,
	output logic                       out_free,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [u8v_pkg::BYTE_W-1:0] m_axis_tdata
);
	import u8v_pkg::*;

	logic valid_q;
	logic verdict_q;

	assign out_free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			verdict_q <= verdict;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(BYTE_W-1){1'b0}}, verdict_q};

endmodule

/* rtl/core/utf8_string_validator.sv */
// ---------------------------------------------------------------------------
// UTF-8 string validator
// Checks a byte stream as strict UTF-8 within a programmable length limit
// and reports one verdict beat per string.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata = data_byte, tuser = has_byte, tlast = is_last
//   m_axis    out        tdata[0] = string_valid, upper bits zero
//   cfg       in         cfg_data = max_length
//
// One input beat per cycle is sustained unless a closing beat waits for the
// result register. A beat is registered in the input stage and decoded by one
// level of logic in the following cycle; a closing beat loads its verdict into
// the result register, setting m_axis_tvalid, when it leaves the input. Reset
// clears the string state and sets max_length to 128. While a verdict waits
// unclaimed, the input stage still takes and decodes beats that do not close
// a string; only a second closing beat stalls until the result register frees.
//
module utf8_string_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [u8v_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic                       s_axis_tuser,  // [0] has_byte
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [u8v_pkg::BYTE_W-1:0] m_axis_tdata,  // [0] string_valid, [7:1] zero
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [u8v_pkg::BYTE_W-1:0] cfg_data
);
	import u8v_pkg::*;

	logic [BYTE_W-1:0] max_length_q;
	stage_t            stage;
	logic              out_free;
	logic              verdict;

	// The limit register takes a write in any cycle; the user is to change it only
	// between strings, which the block does not enforce, and it has no decoder interlock.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_length_q <= cfg_data;
		end
	end

	// Input stage: holds the accepted beat for the decoder.
	u8v_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.out_free      (out_free),
		.stage         (stage)
	);

	// Decoder: byte count, open sequence and the sticky failure flag. The
	// verdict it forms already includes the byte of the closing beat.
	u8v_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage      (stage),
		.max_length (max_length_q),
		.verdict    (verdict)
	);

	// Result register: loads only when a closing beat leaves the input stage.
	u8v_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (stage.step && stage.beat.is_last),
		.verdict       (verdict),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

/* rtl/core/u8v_checker.sv */
// ---------------------------------------------------------------------------
// UTF-8 validator port checker
// Port-level properties of the validator, attached to it by a bind.
// ---------------------------------------------------------------------------
`include "utf8_string_validator_assert.svh"

module u8v_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [u8v_pkg::BYTE_W-1:0] s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  logic                       s_axis_tlast,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [u8v_pkg::BYTE_W-1:0] m_axis_tdata,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [u8v_pkg::BYTE_W-1:0] cfg_data
);

	// A held verdict beat keeps its value until taken.
	`U8V_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "verdict beat dropped or changed while stalled")

	// The input side only backs up behind an unclaimed verdict.
	`U8V_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with the result side free")

	// A fresh verdict follows a closing beat accepted through the input stage.
	`U8V_ASSERT_NOW(a_verdict_src, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "verdict without a closing beat")

endmodule

bind utf8_string_validator u8v_checker u_u8v_checker (.*);
